/* rtl/ddr_pkg.sv */
// Shared types, constants and single-step functions for the direction
// deflection pipeline: square root, division and CORDIC steps.
// No dependencies.
package ddr_pkg;

  localparam int FRAC_BITS = 22;
  localparam int UP_SHIFT  = 30 - FRAC_BITS;

  localparam logic signed [24:0] ONE_Q    = 25'(1 << FRAC_BITS);
  localparam logic signed [48:0] T2_FULL  = 49'(1) << (2 * FRAC_BITS);
  localparam logic signed [31:0] Q30_ONE  = 32'sh4000_0000;
  localparam logic signed [33:0] GAIN_Q30 = 34'sh0_26DD_3B6A;
  localparam logic signed [33:0] QUARTER  = 34'sh0_4000_0000;
  localparam logic signed [33:0] HALF     = 34'sh0_8000_0000;

  typedef struct packed {
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    logic [24:0] rem;
    logic [30:0] q;
  } dv_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } cs_t;

  typedef struct packed {
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic signed [23:0] vz;
    logic               cneg;
    logic               pass;
  } side_t;

  typedef struct packed {
    side_t              base;
    logic signed [23:0] tx;
    logic signed [23:0] ty;
    logic [23:0]        rho;
    logic [23:0]        r;
  } side2_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(logic [4:0] i);
    logic [31:0] a;
    unique case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

  // one result bit of a floor square root; radicand consumed from the top
  function automatic sq_t sqrt_step(sq_t s);
    sq_t         o;
    logic [33:0] rem2;
    logic [33:0] trial;
    rem2  = {s.rem[31:0], s.rad[63:62]};
    trial = {s.root, 2'b01};
    o.rad = {s.rad[61:0], 2'b00};
    if (rem2 >= trial) begin
      o.rem  = rem2 - trial;
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = rem2;
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  // one quotient bit; remainder leaves already doubled for the next step
  function automatic dv_t div_step(dv_t s, logic [23:0] den);
    dv_t         o;
    logic [24:0] diff;
    if (s.rem >= {1'b0, den}) begin
      diff = s.rem - {1'b0, den};
      o.q  = {s.q[29:0], 1'b1};
    end else begin
      diff = s.rem;
      o.q  = {s.q[29:0], 1'b0};
    end
    o.rem = {diff[23:0], 1'b0};
    return o;
  endfunction

  function automatic cs_t cordic_step(cs_t s, int i);
    cs_t                o;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] at;
    dx = $signed(s.y) >>> i;
    dy = $signed(s.x) >>> i;
    at = $signed({2'b00, atan_turn(5'(i))});
    if (!s.z[33]) begin
      o.x = s.x - dx;
      o.y = s.y + dy;
      o.z = s.z - at;
    end else begin
      o.x = s.x + dx;
      o.y = s.y - dy;
      o.z = s.z + at;
    end
    return o;
  endfunction

  function automatic logic [23:0] mag24(logic signed [23:0] v);
    return v[23] ? 24'(-v) : 24'(v);
  endfunction

  // round half up from scale 2^30 and clamp to 24 bits
  function automatic logic [23:0] round_sat(logic signed [57:0] v);
    logic signed [57:0] t;
    t = (v + 58'sd536870912) >>> 30;
    if (t > 58'sd8388607) begin
      return 24'h7FFFFF;
    end else if (t < -58'sd8388608) begin
      return 24'h800000;
    end else begin
      return t[23:0];
    end
  endfunction

endpackage

/* rtl/direction_deflection_rotation.sv */
// Direction deflection: rotates a direction vector by a polar cosine and an
// azimuth angle in turns, fully pipelined. Depends on ddr_pkg.
//
// One request enters every cycle unless the output stalls; the pipe holds
// max(CORDIC_STEPS, 24) + 40 register stages. The depth is set by the
// square-root / CORDIC section (one root bit or one rotation per stage) and
// the 31-stage restoring dividers that form the azimuth and zenith cosines
// and sines. The whole pipe advances together: when the output is held by
// m_tready low, the pipe stalls and s_tready drops.
// Q1.22 vectors and cosine, azimuth in 2^-24 turn; rounded half up, saturated.
module direction_deflection_rotation #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // dir_x, dir_y, dir_z, cos_polar, azimuth_turn (24 bits each)
  input  logic [119:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // new_x, new_y, new_z (24 bits each)
  output logic [71:0]  m_tdata
);
  import ddr_pkg::*;

  localparam int L3     = (CORDIC_STEPS > 24) ? CORDIC_STEPS : 24;
  localparam int DSTEPS = 31;
  localparam int LAT    = L3 + 40;
  localparam int P7END  = L3 + 36;

  logic           en;
  logic [LAT-1:0] vld;

  assign m_tvalid = vld[LAT-1];
  assign en       = !vld[LAT-1] || m_tready;
  assign s_tready = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // stage 0: input register
  logic signed [23:0] c0;
  logic [23:0]        turn0;
  side_t              sd0;

  always_ff @(posedge clk) begin
    if (en) begin
      sd0   <= '{vx:   $signed(s_tdata[23:0]),
                 vy:   $signed(s_tdata[47:24]),
                 vz:   $signed(s_tdata[71:48]),
                 cneg: s_tdata[95],
                 pass: (s_tdata[95:72] == 24'(ONE_Q)) && (s_tdata[119:96] == '0)};
      c0    <= $signed(s_tdata[95:72]);
      turn0 <= s_tdata[119:96];
    end
  end

  // stage 1: squares, 1 -/+ c
  side_t              sd1;
  logic [23:0]        turn1;
  logic [46:0]        xx1, yy1, zz1;
  logic signed [24:0] omc1, opc1;
  logic signed [47:0] xx_p, yy_p, zz_p;

  assign xx_p = sd0.vx * sd0.vx;
  assign yy_p = sd0.vy * sd0.vy;
  assign zz_p = sd0.vz * sd0.vz;

  always_ff @(posedge clk) begin
    if (en) begin
      sd1      <= sd0;
      turn1    <= turn0;
      xx1      <= xx_p[46:0];
      yy1      <= yy_p[46:0];
      zz1      <= zz_p[46:0];
      omc1     <= ONE_Q - 25'(c0);
      opc1     <= ONE_Q + 25'(c0);
    end
  end

  // stage 2: radicands, CORDIC fold
  side_t              sd2;
  logic [47:0]        s2p2, sxy2, sxyz2;
  cs_t                cs2;
  logic signed [49:0] s2_p;
  logic signed [33:0] z_init;
  cs_t                cs_fold;

  assign s2_p   = omc1 * opc1;
  assign z_init = 34'($signed({turn1, 8'h00}));

  always_comb begin
    cs_fold.x = GAIN_Q30;
    cs_fold.y = '0;
    cs_fold.z = z_init;
    if (z_init > QUARTER) begin
      cs_fold.z = z_init - HALF;
      cs_fold.x = -GAIN_Q30;
    end else if (z_init < -QUARTER) begin
      cs_fold.z = z_init + HALF;
      cs_fold.x = -GAIN_Q30;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd2   <= sd1;
      s2p2  <= (!s2_p[49] && (s2_p != '0)) ? s2_p[47:0] : '0;
      sxy2  <= 48'(xx1) + 48'(yy1);
      sxyz2 <= 48'(xx1) + 48'(yy1) + 48'(zz1);
      cs2   <= cs_fold;
    end
  end

  // stages 3..: sqrt of s2, rho, r and CORDIC rotations
  sq_t   sq_sp  [L3];
  sq_t   sq_rho [L3];
  sq_t   sq_r   [L3];
  cs_t   cs3    [L3];
  side_t sd3    [L3];

  for (genvar k = 0; k < L3; k++) begin : g_p3
    sq_t   sp_in, rho_in, r_in;
    cs_t   cs_in;
    side_t sd_in;
    if (k == 0) begin : g_first
      assign sp_in  = '{rad: 64'(s2p2) << (64 - 2 * L3), rem: '0, root: '0};
      assign rho_in = '{rad: 64'(sxy2) << (64 - 2 * L3), rem: '0, root: '0};
      assign r_in   = '{rad: 64'(sxyz2) << (64 - 2 * L3), rem: '0, root: '0};
      assign cs_in  = cs2;
      assign sd_in  = sd2;
    end else begin : g_next
      assign sp_in  = sq_sp[k-1];
      assign rho_in = sq_rho[k-1];
      assign r_in   = sq_r[k-1];
      assign cs_in  = cs3[k-1];
      assign sd_in  = sd3[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_sp[k]  <= sqrt_step(sp_in);
        sq_rho[k] <= sqrt_step(rho_in);
        sq_r[k]   <= sqrt_step(r_in);
        cs3[k]    <= (k < CORDIC_STEPS) ? cordic_step(cs_in, k) : cs_in;
        sd3[k]    <= sd_in;
      end
    end
  end

  // tx, ty
  side2_t             sd4;
  logic signed [58:0] txp, typ;

  assign txp = $signed({1'b0, sq_sp[L3-1].root[23:0]}) * cs3[L3-1].x + 59'sd536870912;
  assign typ = $signed({1'b0, sq_sp[L3-1].root[23:0]}) * cs3[L3-1].y + 59'sd536870912;

  always_ff @(posedge clk) begin
    if (en) begin
      sd4 <= '{base: sd3[L3-1],
               tx:   txp[53:30],
               ty:   typ[53:30],
               rho:  sq_rho[L3-1].root[23:0],
               r:    sq_r[L3-1].root[23:0]};
    end
  end

  side2_t             sd5, sd6;
  logic signed [47:0] tx2_5, ty2_5;
  logic [44:0]        t2p6;
  logic signed [48:0] t2_d;

  assign t2_d = T2_FULL - 49'(tx2_5) - 49'(ty2_5);

  always_ff @(posedge clk) begin
    if (en) begin
      sd5   <= sd4;
      tx2_5 <= sd4.tx * sd4.tx;
      ty2_5 <= sd4.ty * sd4.ty;
      sd6   <= sd5;
      t2p6  <= (!t2_d[48] && (t2_d != '0)) ? t2_d[44:0] : '0;
    end
  end

  // sqrt of t2 beside the four quotients x/rho, y/rho, z/r, rho/r
  sq_t    sq_tz [DSTEPS];
  dv_t    dv    [DSTEPS][4];
  side2_t sd7   [DSTEPS];

  for (genvar k = 0; k < DSTEPS; k++) begin : g_p7
    sq_t    tz_in;
    side2_t s_in;
    dv_t    d_in [4];
    if (k == 0) begin : g_first
      assign tz_in   = '{rad: 64'(t2p6) << (64 - 2 * DSTEPS), rem: '0, root: '0};
      assign s_in    = sd6;
      assign d_in[0] = '{rem: {1'b0, mag24(sd6.base.vx)}, q: '0};
      assign d_in[1] = '{rem: {1'b0, mag24(sd6.base.vy)}, q: '0};
      assign d_in[2] = '{rem: {1'b0, mag24(sd6.base.vz)}, q: '0};
      assign d_in[3] = '{rem: {1'b0, sd6.rho}, q: '0};
    end else begin : g_next
      assign tz_in = sq_tz[k-1];
      assign s_in  = sd7[k-1];
      for (genvar j = 0; j < 4; j++) begin : g_d
        assign d_in[j] = dv[k-1][j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_tz[k] <= sqrt_step(tz_in);
        sd7[k]   <= s_in;
        dv[k][0] <= div_step(d_in[0], s_in.rho);
        dv[k][1] <= div_step(d_in[1], s_in.rho);
        dv[k][2] <= div_step(d_in[2], s_in.r);
        dv[k][3] <= div_step(d_in[3], s_in.r);
      end
    end
  end

  // signed quotients, degenerate axes, ex products
  logic signed [31:0] qm [4];
  logic signed [31:0] cph, sph, cth, sth;
  logic signed [23:0] tzm;
  logic signed [63:0] exx_p, exy_p;
  logic               rho_zero, r_zero;

  assign rho_zero = (sd7[DSTEPS-1].rho == '0);
  assign r_zero   = (sd7[DSTEPS-1].r == '0);
  assign qm[0] = sd7[DSTEPS-1].base.vx[23] ? -$signed({1'b0, dv[DSTEPS-1][0].q})
                                           : $signed({1'b0, dv[DSTEPS-1][0].q});
  assign qm[1] = sd7[DSTEPS-1].base.vy[23] ? -$signed({1'b0, dv[DSTEPS-1][1].q})
                                           : $signed({1'b0, dv[DSTEPS-1][1].q});
  assign qm[2] = sd7[DSTEPS-1].base.vz[23] ? -$signed({1'b0, dv[DSTEPS-1][2].q})
                                           : $signed({1'b0, dv[DSTEPS-1][2].q});
  assign qm[3] = $signed({1'b0, dv[DSTEPS-1][3].q});
  assign cph   = rho_zero ? Q30_ONE : qm[0];
  assign sph   = rho_zero ? '0 : qm[1];
  assign cth   = r_zero ? Q30_ONE : qm[2];
  assign sth   = r_zero ? '0 : qm[3];
  assign tzm   = $signed({1'b0, sq_tz[DSTEPS-1].root[22:0]});
  assign exx_p = cth * cph + 64'sd536870912;
  assign exy_p = cth * sph + 64'sd536870912;

  side2_t             sd8;
  logic signed [23:0] tz8;
  logic signed [31:0] exx8, exy8, exz8, eyx8, eyy8;

  always_ff @(posedge clk) begin
    if (en) begin
      sd8  <= sd7[DSTEPS-1];
      tz8  <= sd7[DSTEPS-1].base.cneg ? -tzm : tzm;
      exx8 <= exx_p[61:30];
      exy8 <= exy_p[61:30];
      exz8 <= -sth;
      eyx8 <= -sph;
      eyy8 <= cph;
    end
  end

  // partial products
  side_t              sd9;
  logic signed [47:0] a9 [3];
  logic signed [55:0] b9 [3];
  logic signed [55:0] c9 [2];

  always_ff @(posedge clk) begin
    if (en) begin
      sd9   <= sd8.base;
      a9[0] <= tz8 * sd8.base.vx;
      a9[1] <= tz8 * sd8.base.vy;
      a9[2] <= tz8 * sd8.base.vz;
      b9[0] <= sd8.tx * exx8;
      b9[1] <= sd8.tx * exy8;
      b9[2] <= sd8.tx * exz8;
      c9[0] <= sd8.ty * eyx8;
      c9[1] <= sd8.ty * eyy8;
    end
  end

  // sum at scale 2^30, round, saturate
  logic signed [57:0] sum [3];
  logic signed [57:0] a_up [3];

  for (genvar j = 0; j < 3; j++) begin : g_up
    assign a_up[j] = 58'(a9[j]) <<< UP_SHIFT;
  end
  assign sum[0] = a_up[0] + 58'(b9[0]) + 58'(c9[0]);
  assign sum[1] = a_up[1] + 58'(b9[1]) + 58'(c9[1]);
  assign sum[2] = a_up[2] + 58'(b9[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      if (sd9.pass) begin
        m_tdata <= {sd9.vz, sd9.vy, sd9.vx};
      end else begin
        m_tdata <= {round_sat(sum[2]), round_sat(sum[1]), round_sat(sum[0])};
      end
    end
  end

  a_shift: assert property (@(posedge clk) disable iff (rst)
    en |=> vld[LAT-1:1] == $past(vld[LAT-2:0]))
    else $error("valid bits did not advance with the pipe");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> vld == $past(vld))
    else $error("valid bits moved during a stall");

  a_tz_range: assert property (@(posedge clk) disable iff (rst)
    vld[P7END] |-> sq_tz[DSTEPS-1].root[31:23] == '0)
    else $error("tz root beyond one");

  a_quot_range: assert property (@(posedge clk) disable iff (rst)
    vld[P7END] && sd7[DSTEPS-1].rho != '0 |-> dv[DSTEPS-1][0].q <= 31'h4000_0000)
    else $error("azimuth cosine quotient beyond one");

endmodule
